@@ hdl/hlrr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Hemisphere lens remap package
// Register indexes, register widths and reset values, and default sizes.
// ----------------------------------------------------------------------------
package hlrr_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;

  // Widths of the configuration registers.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int CENTER_W   = 17;
  localparam int RADIUS_W   = 9;
  localparam int RATIO_W    = 16;
  localparam int BOUND_W    = 13;

  // The lens centre and the internal offsets are in sixteenths of a pixel.
  localparam int SUBPIX_BITS = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X     = 3'd0,
    REG_CENTER_Y     = 3'd1,
    REG_LENS_RADIUS  = 3'd2,
    REG_RATIO        = 3'd3,
    REG_IMAGE_WIDTH  = 3'd4,
    REG_IMAGE_HEIGHT = 3'd5
  } cfg_reg_t;

  localparam logic signed [CENTER_W-1:0] CENTER_RST = '0;
  localparam logic [RADIUS_W-1:0]        RADIUS_RST = 9'd100;
  localparam logic [RATIO_W-1:0]         RATIO_RST  = 16'd43116;
  localparam logic [BOUND_W-1:0]         WIDTH_RST  = 13'd1024;
  localparam logic [BOUND_W-1:0]         HEIGHT_RST = 13'd768;

endpackage
`default_nettype wire

@@ hdl/hemisphere_lens_refraction_remap.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Hemisphere lens refraction remap
// Maps a destination pixel to the source pixel seen through a hemispherical
// lens, with a flag that says whether the pixel is replaced.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  in_     | input     | in_valid/in_stall  | pixel_x, pixel_y
//  out_    | output    | out_valid/out_stall| source_x, source_y, take_sample
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One beat enters per clock while the output is not stalled. The pipeline
// holds two bit-serial square roots (radius bits plus four, then FRAC_BITS+1
// steps), the three normal dividers (FRAC_BITS+1 steps) and the projection
// dividers (13 steps). Synchronous active-low reset clears the valid bits and
// resets the registers. An output stall with the last stage full freezes every
// stage; nothing is dropped or repeated. cfg_ready is always high; registers
// are read live by the stages.
// ----------------------------------------------------------------------------
module hemisphere_lens_refraction_remap #(
  parameter int COORD_BITS = hlrr_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = hlrr_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [COORD_BITS-1:0]           in_pixel_x,
  input  wire logic [COORD_BITS-1:0]           in_pixel_y,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [COORD_BITS-1:0]                out_source_x,
  output logic [COORD_BITS-1:0]                out_source_y,
  output logic                                 out_take_sample,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [hlrr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hlrr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hlrr_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int FB  = FRAC_BITS;
  localparam int DW  = ((CB + SUBPIX_BITS > CENTER_W - 1) ? CB + SUBPIX_BITS
                                                          : CENTER_W - 1) + 2;
  localparam int ZB  = RADIUS_W + SUBPIX_BITS;
  localparam int ZA  = 2 * ZB;
  localparam int QN  = FB + 1;
  localparam int RW  = ZB + FB + 1;
  localparam int SB  = FB + 1;
  localparam int SA  = 2 * SB;
  localparam int TPW = 2 * FB + 4;
  localparam int DNW = FB + 2 + SUBPIX_BITS;
  localparam int PAW = CB + DNW;
  localparam int PBW = FB + ZB + 3;
  localparam int NW  = ((PAW > PBW) ? PAW : PBW) + 1;
  localparam int QB  = BOUND_W;
  localparam int CW  = ((NW > DNW + QB) ? NW : DNW + QB) + 1;
  localparam int AW  = CB + BOUND_W;

  localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

  // Stage schedule.
  localparam int J_SQ  = 1;
  localparam int J_D2  = 2;
  localparam int J_Z0  = 3;
  localparam int J_DI  = J_Z0 + ZB;
  localparam int J_D0  = J_DI + 1;
  localparam int J_M1  = J_D0 + QN;
  localparam int J_M2  = J_M1 + 1;
  localparam int J_M3  = J_M2 + 1;
  localparam int J_S0  = J_M3 + 1;
  localparam int J_C   = J_S0 + SB;
  localparam int J_T   = J_C + 1;
  localparam int J_Z   = J_T + 1;
  localparam int J_P   = J_Z + 1;
  localparam int J_N   = J_P + 1;
  localparam int J_A   = J_N + 1;
  localparam int J_Q0  = J_A + 1;
  localparam int LAST  = J_Q0 + QB;

  typedef struct packed {
    logic [CB-1:0]          px;
    logic [CB-1:0]          py;
    logic signed [DW-1:0]   dx;
    logic signed [DW-1:0]   dy;
    logic [2*DW-1:0]        sqx;
    logic [2*DW-1:0]        sqy;
    logic                   skip;
    logic                   negx;
    logic                   negy;
    logic [ZB-1:0]          ax;
    logic [ZB-1:0]          ay;
    logic [ZA-1:0]          zrem;
    logic [ZB-1:0]          z;
    logic [RW-1:0]          rx;
    logic [RW-1:0]          ry;
    logic [RW-1:0]          rz;
    logic [QN-1:0]          qx;
    logic [QN-1:0]          qy;
    logic [QN-1:0]          qz;
    logic signed [FB+1:0]   nx;
    logic signed [FB+1:0]   ny;
    logic [FB:0]            nz;
    logic [FB:0]            nzsq;
    logic [FB:0]            munz;
    logic [FB:0]            ms;
    logic [SA-1:0]          srem;
    logic [SB-1:0]          sk;
    logic signed [FB+1:0]   c;
    logic signed [FB+1:0]   tr_x;
    logic signed [FB+1:0]   tr_y;
    logic signed [FB+1:0]   tz;
    logic [FB+1:0]          den;
    logic [PAW-1:0]         pax;
    logic [PAW-1:0]         pay;
    logic signed [PBW-1:0]  pbx;
    logic signed [PBW-1:0]  pby;
    logic signed [NW-1:0]   numx;
    logic signed [NW-1:0]   numy;
    logic [DNW-1:0]         d16;
    logic [NW-1:0]          magx;
    logic [NW-1:0]          magy;
    logic                   nsx;
    logic                   nsy;
    logic                   ovx;
    logic                   ovy;
    logic [QB-1:0]          sx;
    logic [QB-1:0]          sy;
    logic [CB-1:0]          osx;
    logic [CB-1:0]          osy;
    logic                   take;
  } item_t;

  // Configuration registers.
  logic signed [CENTER_W-1:0] cx_r;
  logic signed [CENTER_W-1:0] cy_r;
  logic [RADIUS_W-1:0]        rad_r;
  logic [RATIO_W-1:0]         ratio_r;
  logic [BOUND_W-1:0]         wid_r;
  logic [BOUND_W-1:0]         hgt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r    <= CENTER_RST;
      cy_r    <= CENTER_RST;
      rad_r   <= RADIUS_RST;
      ratio_r <= RATIO_RST;
      wid_r   <= WIDTH_RST;
      hgt_r   <= HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CENTER_X:     cx_r    <= cfg_data[CENTER_W-1:0];
        REG_CENTER_Y:     cy_r    <= cfg_data[CENTER_W-1:0];
        REG_LENS_RADIUS:  rad_r   <= cfg_data[RADIUS_W-1:0];
        REG_RATIO:        ratio_r <= cfg_data[RATIO_W-1:0];
        REG_IMAGE_WIDTH:  wid_r   <= cfg_data[BOUND_W-1:0];
        REG_IMAGE_HEIGHT: hgt_r   <= cfg_data[BOUND_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // Values derived from the registers; they settle long before a beat needs them.
  logic [ZB-1:0]         r16;
  logic [ZA-1:0]         r16sq_r;
  logic [FB-1:0]         mu_r;
  logic [FB-1:0]         mu2_r;
  logic [RATIO_W+FB-1:0] mu_ext;
  logic [2*FB-1:0]       mu_prod;

  assign r16     = {rad_r, {SUBPIX_BITS{1'b0}}};
  assign mu_ext  = {ratio_r, {FB{1'b0}}};
  assign mu_prod = mu_r * mu_r;

  always_ff @(posedge clk) begin
    r16sq_r <= r16 * r16;
    mu_r    <= FB'(mu_ext >> RATIO_W);
    mu2_r   <= mu_prod[2*FB-1:FB];
  end

  // Q-format product scaled back by ONE, truncated toward zero.
  function automatic logic signed [FB+1:0] qtr(input logic signed [TPW-1:0] p);
    logic signed [TPW-1:0] sh;
    sh = p >>> FB;
    if (p[TPW-1] && (p[FB-1:0] != '0)) begin
      sh = sh + TPW'(1);
    end
    return sh[FB+1:0];
  endfunction

  logic [LAST:0] vld_r;
  item_t         st_r [0:LAST];
  item_t         st0_nxt;
  logic          adv;

  assign adv      = !vld_r[LAST] || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAST-1:0], in_valid};
    end
  end

  always_comb begin
    st0_nxt    = '0;
    st0_nxt.px = in_pixel_x;
    st0_nxt.py = in_pixel_y;
    st0_nxt.dx = DW'($signed({1'b0, in_pixel_x, {SUBPIX_BITS{1'b0}}})) - DW'(cx_r);
    st0_nxt.dy = DW'($signed({1'b0, in_pixel_y, {SUBPIX_BITS{1'b0}}})) - DW'(cy_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= st0_nxt;
    end
  end

  for (genvar j = 1; j <= LAST; j++) begin : g_stg
    item_t stg_nxt;

    if (j == J_SQ) begin : g_sq
      always_comb begin
        stg_nxt     = st_r[j-1];
        stg_nxt.sqx = st_r[j-1].dx * st_r[j-1].dx;
        stg_nxt.sqy = st_r[j-1].dy * st_r[j-1].dy;
      end
    end else if (j == J_D2) begin : g_d2
      always_comb begin
        logic [2*DW:0]        d2;
        logic signed [DW-1:0] adx;
        logic signed [DW-1:0] ady;
        d2   = {1'b0, st_r[j-1].sqx} + {1'b0, st_r[j-1].sqy};
        adx  = st_r[j-1].dx[DW-1] ? -st_r[j-1].dx : st_r[j-1].dx;
        ady  = st_r[j-1].dy[DW-1] ? -st_r[j-1].dy : st_r[j-1].dy;
        stg_nxt      = st_r[j-1];
        stg_nxt.skip = (rad_r == '0) || (d2 > (2*DW+1)'(r16sq_r));
        stg_nxt.negx = st_r[j-1].dx[DW-1];
        stg_nxt.negy = st_r[j-1].dy[DW-1];
        stg_nxt.ax   = adx[ZB-1:0];
        stg_nxt.ay   = ady[ZB-1:0];
        stg_nxt.zrem = r16sq_r - d2[ZA-1:0];
        stg_nxt.z    = '0;
      end
    end else if (j >= J_Z0 && j < J_DI) begin : g_zsqrt
      localparam int B = ZB - 1 - (j - J_Z0);
      always_comb begin
        logic [ZA:0] trial;
        trial   = ((ZA+1)'(st_r[j-1].z) << (B + 1)) + ((ZA+1)'(1) << (2 * B));
        stg_nxt = st_r[j-1];
        if ({1'b0, st_r[j-1].zrem} >= trial) begin
          stg_nxt.zrem = st_r[j-1].zrem - trial[ZA-1:0];
          stg_nxt.z[B] = 1'b1;
        end
      end
    end else if (j == J_DI) begin : g_dinit
      always_comb begin
        stg_nxt    = st_r[j-1];
        stg_nxt.rx = RW'(st_r[j-1].ax) << FB;
        stg_nxt.ry = RW'(st_r[j-1].ay) << FB;
        stg_nxt.rz = RW'(st_r[j-1].z) << FB;
        stg_nxt.qx = '0;
        stg_nxt.qy = '0;
        stg_nxt.qz = '0;
      end
    end else if (j >= J_D0 && j < J_M1) begin : g_div
      localparam int B = QN - 1 - (j - J_D0);
      always_comb begin
        logic [RW:0] trial;
        trial   = (RW+1)'(r16) << B;
        stg_nxt = st_r[j-1];
        if ({1'b0, st_r[j-1].rx} >= trial) begin
          stg_nxt.rx    = st_r[j-1].rx - trial[RW-1:0];
          stg_nxt.qx[B] = 1'b1;
        end
        if ({1'b0, st_r[j-1].ry} >= trial) begin
          stg_nxt.ry    = st_r[j-1].ry - trial[RW-1:0];
          stg_nxt.qy[B] = 1'b1;
        end
        if ({1'b0, st_r[j-1].rz} >= trial) begin
          stg_nxt.rz    = st_r[j-1].rz - trial[RW-1:0];
          stg_nxt.qz[B] = 1'b1;
        end
      end
    end else if (j == J_M1) begin : g_m1
      always_comb begin
        logic [FB:0]          nzc;
        logic [2*FB+1:0]      p_nn;
        logic [2*FB:0]        p_mn;
        logic signed [FB+1:0] qxs;
        logic signed [FB+1:0] qys;
        nzc  = (st_r[j-1].qz > ONE) ? ONE : st_r[j-1].qz;
        p_nn = nzc * nzc;
        p_mn = mu_r * nzc;
        qxs  = $signed({1'b0, st_r[j-1].qx});
        qys  = $signed({1'b0, st_r[j-1].qy});
        stg_nxt      = st_r[j-1];
        stg_nxt.nx   = st_r[j-1].negx ? -qxs : qxs;
        stg_nxt.ny   = st_r[j-1].negy ? -qys : qys;
        stg_nxt.nz   = nzc;
        stg_nxt.nzsq = p_nn[2*FB:FB];
        stg_nxt.munz = p_mn[2*FB:FB];
      end
    end else if (j == J_M2) begin : g_m2
      always_comb begin
        logic [FB:0]   s;
        logic [2*FB:0] p_ms;
        s    = ONE - st_r[j-1].nzsq;
        p_ms = mu2_r * s;
        stg_nxt    = st_r[j-1];
        stg_nxt.ms = p_ms[2*FB:FB];
      end
    end else if (j == J_M3) begin : g_m3
      always_comb begin
        logic [FB:0] k;
        k = ONE - st_r[j-1].ms;
        stg_nxt      = st_r[j-1];
        // A non-positive k would be total internal reflection.
        stg_nxt.skip = st_r[j-1].skip || (st_r[j-1].ms >= ONE);
        stg_nxt.srem = SA'(k) << FB;
        stg_nxt.sk   = '0;
      end
    end else if (j >= J_S0 && j < J_C) begin : g_ksqrt
      localparam int B = SB - 1 - (j - J_S0);
      always_comb begin
        logic [SA:0] trial;
        trial   = ((SA+1)'(st_r[j-1].sk) << (B + 1)) + ((SA+1)'(1) << (2 * B));
        stg_nxt = st_r[j-1];
        if ({1'b0, st_r[j-1].srem} >= trial) begin
          stg_nxt.srem  = st_r[j-1].srem - trial[SA-1:0];
          stg_nxt.sk[B] = 1'b1;
        end
      end
    end else if (j == J_C) begin : g_c
      always_comb begin
        stg_nxt   = st_r[j-1];
        stg_nxt.c = $signed({1'b0, st_r[j-1].munz}) - $signed({1'b0, st_r[j-1].sk});
      end
    end else if (j == J_T) begin : g_t
      always_comb begin
        logic signed [FB+1:0] nzs;
        nzs = $signed({1'b0, st_r[j-1].nz});
        stg_nxt      = st_r[j-1];
        stg_nxt.tr_x = qtr(st_r[j-1].nx * st_r[j-1].c);
        stg_nxt.tr_y = qtr(st_r[j-1].ny * st_r[j-1].c);
        stg_nxt.tz   = qtr(nzs * st_r[j-1].c);
      end
    end else if (j == J_Z) begin : g_z
      always_comb begin
        logic signed [FB+2:0] trz;
        logic signed [FB+2:0] ntrz;
        trz  = $signed({st_r[j-1].tz[FB+1], st_r[j-1].tz}) - $signed({3'b000, mu_r});
        ntrz = -trz;
        stg_nxt      = st_r[j-1];
        // The ray must head down toward the image plane.
        stg_nxt.skip = st_r[j-1].skip || !trz[FB+2];
        stg_nxt.den  = ntrz[FB+1:0];
      end
    end else if (j == J_P) begin : g_p
      always_comb begin
        logic [DNW-1:0]       d16;
        logic signed [ZB:0]   zs;
        d16 = {st_r[j-1].den, {SUBPIX_BITS{1'b0}}};
        zs  = $signed({1'b0, st_r[j-1].z});
        stg_nxt     = st_r[j-1];
        stg_nxt.d16 = d16;
        stg_nxt.pax = st_r[j-1].px * d16;
        stg_nxt.pay = st_r[j-1].py * d16;
        stg_nxt.pbx = st_r[j-1].tr_x * zs;
        stg_nxt.pby = st_r[j-1].tr_y * zs;
      end
    end else if (j == J_N) begin : g_n
      always_comb begin
        stg_nxt      = st_r[j-1];
        stg_nxt.numx = NW'($signed({1'b0, st_r[j-1].pax})) + NW'(st_r[j-1].pbx);
        stg_nxt.numy = NW'($signed({1'b0, st_r[j-1].pay})) + NW'(st_r[j-1].pby);
      end
    end else if (j == J_A) begin : g_a
      always_comb begin
        logic [NW-1:0] mx;
        logic [NW-1:0] my;
        logic [CW-1:0] lim;
        mx  = st_r[j-1].numx[NW-1] ? NW'(-st_r[j-1].numx) : NW'(st_r[j-1].numx);
        my  = st_r[j-1].numy[NW-1] ? NW'(-st_r[j-1].numy) : NW'(st_r[j-1].numy);
        lim = CW'(st_r[j-1].d16) << QB;
        stg_nxt      = st_r[j-1];
        stg_nxt.nsx  = st_r[j-1].numx[NW-1];
        stg_nxt.nsy  = st_r[j-1].numy[NW-1];
        stg_nxt.magx = mx;
        stg_nxt.magy = my;
        // A quotient that does not fit the bound width is out of the image.
        stg_nxt.ovx  = CW'(mx) >= lim;
        stg_nxt.ovy  = CW'(my) >= lim;
        stg_nxt.sx   = '0;
        stg_nxt.sy   = '0;
      end
    end else if (j >= J_Q0 && j < LAST) begin : g_quo
      localparam int B = QB - 1 - (j - J_Q0);
      always_comb begin
        logic [CW-1:0] trial;
        trial   = CW'(st_r[j-1].d16) << B;
        stg_nxt = st_r[j-1];
        if (CW'(st_r[j-1].magx) >= trial) begin
          stg_nxt.magx  = st_r[j-1].magx - trial[NW-1:0];
          stg_nxt.sx[B] = 1'b1;
        end
        if (CW'(st_r[j-1].magy) >= trial) begin
          stg_nxt.magy  = st_r[j-1].magy - trial[NW-1:0];
          stg_nxt.sy[B] = 1'b1;
        end
      end
    end else begin : g_out
      always_comb begin
        logic okx;
        logic oky;
        logic tk;
        // Truncation toward zero: a negative numerator is in range only as zero.
        okx = !st_r[j-1].ovx && (!st_r[j-1].nsx || (st_r[j-1].sx == '0))
              && (st_r[j-1].sx < wid_r);
        oky = !st_r[j-1].ovy && (!st_r[j-1].nsy || (st_r[j-1].sy == '0))
              && (st_r[j-1].sy < hgt_r);
        tk  = !st_r[j-1].skip && okx && oky;
        stg_nxt      = st_r[j-1];
        stg_nxt.take = tk;
        stg_nxt.osx  = tk ? CB'(st_r[j-1].sx) : '0;
        stg_nxt.osy  = tk ? CB'(st_r[j-1].sy) : '0;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[j] <= stg_nxt;
      end
    end
  end

  assign out_valid       = vld_r[LAST];
  assign out_source_x    = st_r[LAST].osx;
  assign out_source_y    = st_r[LAST].osy;
  assign out_take_sample = st_r[LAST].take;

  a_take_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_take_sample |->
      (AW'(out_source_x) < AW'(wid_r)) && (AW'(out_source_y) < AW'(hgt_r)))
    else $error("taken source coordinate outside the image bounds");

  a_keep_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_take_sample |-> (out_source_x == '0) && (out_source_y == '0))
    else $error("kept pixel carries a nonzero source coordinate");

  a_height_in_lens: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[J_DI-1] && !st_r[J_DI-1].skip |-> st_r[J_DI-1].z <= r16)
    else $error("lens height exceeds the radius");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline valid bits moved during a stall");

endmodule
`default_nettype wire

@@ tb/hlrr_checker.sv @@
// ----------------------------------------------------------------------------
// Hemisphere lens remap checker
// Watches the pixel, result and register channels of the remap block. It
// keeps its own copy of the registers, predicts the source pixel and the
// replace flag for every accepted pixel beat, and compares each result beat
// with the oldest prediction.
// ----------------------------------------------------------------------------
module hlrr_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [11:0] in_pixel_x,
  input  wire logic [11:0] in_pixel_y,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [11:0] out_source_x,
  input  wire logic [11:0] out_source_y,
  input  wire logic        out_take_sample,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [16:0] cfg_data,
  output int               errors,
  output int               pending
);
  import hlrr_pkg::*;

  localparam longint QONE = 64'sd65536;

  typedef struct packed {
    logic [11:0] sx;
    logic [11:0] sy;
    logic        take;
  } remap_t;

  remap_t remap_q[$];

  logic signed [16:0] lens_cx, lens_cy;
  logic [8:0]         lens_r;
  logic [15:0]        mu_reg;
  logic [12:0]        bound_w, bound_h;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bit_q;
    res = 0;
    bit_q = 64'd1 << 62;
    while (bit_q > v) bit_q = bit_q >> 2;
    while (bit_q != 0) begin
      if (v >= res + bit_q) begin
        v = v - (res + bit_q);
        res = (res >> 1) + bit_q;
      end else begin
        res = res >> 1;
      end
      bit_q = bit_q >> 2;
    end
    return res;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return (a * b) / QONE;
  endfunction

  function automatic remap_t predict_remap(logic [11:0] pxi, logic [11:0] pyi);
    remap_t  r;
    longint  px, py, r16, dx, dy, d2, z, nx, ny, nz, mu, s, k, sk, c;
    longint  trx, tryv, trz, den, sx, sy;
    r = '0;
    px = pxi;
    py = pyi;
    r16 = longint'(lens_r) * 16;
    dx = px * 16 - longint'(lens_cx);
    dy = py * 16 - longint'(lens_cy);
    d2 = dx * dx + dy * dy;
    if (r16 == 0 || d2 > r16 * r16) return r;
    z = longint'(int_sqrt(r16 * r16 - d2));
    nx = (dx * QONE) / r16;
    ny = (dy * QONE) / r16;
    nz = (z * QONE) / r16;
    if (nz > QONE) nz = QONE;
    mu = longint'(mu_reg);
    s = QONE - fx_mul(nz, nz);
    k = QONE - fx_mul(fx_mul(mu, mu), s);
    if (k <= 0) return r;
    sk = longint'(int_sqrt(k * QONE));
    c = fx_mul(mu, nz) - sk;
    trx = fx_mul(nx, c);
    tryv = fx_mul(ny, c);
    trz = -mu + fx_mul(nz, c);
    if (trz >= 0) return r;
    den = -trz;
    sx = (px * 16 * den + trx * z) / (16 * den);
    sy = (py * 16 * den + tryv * z) / (16 * den);
    if (sx >= 0 && sx < longint'(bound_w) && sy >= 0 && sy < longint'(bound_h)) begin
      r.sx = sx[11:0];
      r.sy = sy[11:0];
      r.take = 1'b1;
    end
    return r;
  endfunction

  assign pending = remap_q.size();

  always @(posedge clk) begin
    remap_t want;
    if (!rst_n) begin
      lens_cx <= CENTER_RST;
      lens_cy <= CENTER_RST;
      lens_r  <= RADIUS_RST;
      mu_reg  <= RATIO_RST;
      bound_w <= WIDTH_RST;
      bound_h <= HEIGHT_RST;
      errors  <= 0;
      remap_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (remap_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: %h %h %b", $time,
                   out_source_x, out_source_y, out_take_sample);
          errors <= errors + 1;
        end else begin
          want = remap_q.pop_front();
          if (want.take !== out_take_sample || want.sx !== out_source_x ||
              want.sy !== out_source_y) begin
            $display("%0t: mismatch expected x=%0d y=%0d take=%b actual x=%0d y=%0d take=%b",
                     $time, want.sx, want.sy, want.take,
                     out_source_x, out_source_y, out_take_sample);
            errors <= errors + 1;
          end
        end
      end
      // Prediction uses the registers as they stand before this edge.
      if (in_valid && !in_stall) remap_q.push_back(predict_remap(in_pixel_x, in_pixel_y));
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_CENTER_X:     lens_cx <= cfg_data;
          REG_CENTER_Y:     lens_cy <= cfg_data;
          REG_LENS_RADIUS:  lens_r  <= cfg_data[8:0];
          REG_RATIO:        mu_reg  <= cfg_data[15:0];
          REG_IMAGE_WIDTH:  bound_w <= cfg_data[12:0];
          REG_IMAGE_HEIGHT: bound_h <= cfg_data[12:0];
          default: ;
        endcase
      end
    end
  end
endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Hemisphere lens remap testbench
// Drives pixel beats and register writes into the remap block under several
// lens settings and idling patterns; a checker beside the block predicts and
// compares every result beat.
// ----------------------------------------------------------------------------
module testbench;
  import hlrr_pkg::*;

  localparam int LATENCY = 42 + 2 * 16;
  localparam int WATCHDOG = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [11:0] in_pixel_x = '0;
  logic [11:0] in_pixel_y = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] out_source_x, out_source_y;
  logic        out_take_sample;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;

  int errors, pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_recv = 1'b0;
  int idle_cycles = 0;

  always #10 clk = ~clk;

  hemisphere_lens_refraction_remap dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_pixel_x, .in_pixel_y,
    .out_valid, .out_stall, .out_source_x, .out_source_y, .out_take_sample,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  hlrr_checker chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_pixel_x, .in_pixel_y,
    .out_valid, .out_stall, .out_source_x, .out_source_y, .out_take_sample,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .errors, .pending
  );

  // Receiver: random stall, or a held stall while a long hold-off runs.
  always @(negedge clk) begin
    out_stall <= hold_recv || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Valid stays high after a beat so the next beat can follow at once; the
  // caller drops it when the sender goes quiet.
  task automatic send_pixel(input logic [11:0] x, input logic [11:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_x <= x;
    in_pixel_y <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [16:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic set_lens(input logic [16:0] cx, input logic [16:0] cy,
                          input logic [8:0] r, input logic [15:0] mu,
                          input logic [12:0] w, input logic [12:0] h);
    drain();
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_LENS_RADIUS, {8'd0, r});
    write_reg(REG_RATIO, {1'b0, mu});
    write_reg(REG_IMAGE_WIDTH, {4'd0, w});
    write_reg(REG_IMAGE_HEIGHT, {4'd0, h});
    cfg_valid <= 1'b0;
  endtask

  // Mostly pixels near the lens so the refraction path is exercised.
  task automatic random_pixels(input int n, input int cx16, input int cy16,
                               input int r);
    int dx, dy;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 8) begin
        dx = $urandom_range(2 * r + 2) - (r + 1);
        dy = $urandom_range(2 * r + 2) - (r + 1);
        send_pixel(12'((cx16 >>> 4) + dx), 12'((cy16 >>> 4) + dy));
      end else begin
        send_pixel(12'($urandom), 12'($urandom));
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: centre, rim, far corner, extremes of the fields.
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd100, 12'd0);
    send_pixel(12'd0, 12'd100);
    send_pixel(12'd71, 12'd71);
    send_pixel(12'd4095, 12'd0);
    // Lens in the middle of the image; also a zero ratio, where rim rays
    // do not head down, and a source falling outside a small image.
    set_lens(17'd8192, 17'd8192, 9'd200, 16'd43116, 13'd1024, 13'd1024);
    send_pixel(12'd512, 12'd512);
    send_pixel(12'd712, 12'd512);
    send_pixel(12'd512, 12'd312);
    send_pixel(12'd650, 12'd650);
    set_lens(17'd8192, 17'd8192, 9'd200, 16'd0, 13'd1024, 13'd1024);
    send_pixel(12'd712, 12'd512);
    send_pixel(12'd600, 12'd520);
    set_lens(17'h10000, 17'h1FFFF, 9'd511, 16'd65535, 13'd4096, 13'd4096);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd300, 12'd200);
    send_pixel(12'd4095, 12'd4095);
    set_lens(17'd65535, 17'd65535, 9'd1, 16'd30000, 13'd0, 13'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4094, 12'd4095);

    set_lens(17'd8000, 17'd6000, 9'd100, 16'd43116, 13'd4096, 13'd4096);
    send_idle_pct = 35; recv_idle_pct = 84;
    random_pixels(300, 8000, 6000, 100);

    // Long hold-off at the output while pixels keep coming.
    hold_recv = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk);
        hold_recv = 1'b0;
      end
      begin
        random_pixels(200, 8000, 6000, 100);
        in_valid <= 1'b0;
      end
    join

    set_lens(17'($urandom_range(65535)), 17'($urandom_range(65535)),
             9'd300, 16'($urandom), 13'd4000, 13'd3000);
    send_idle_pct = 84; recv_idle_pct = 35;
    random_pixels(250, 32768, 32768, 300);

    // Pause until everything has come back.
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);

    set_lens(17'd16000, 17'd1600, 9'd40, 16'd60000, 13'd2048, 13'd2048);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_pixels(250, 16000, 1600, 40);

    drain();
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
